// ----- hw/rtl/cap_pkg.sv -----
// Shared constants for the conflict-aware offset placer.
`timescale 1ns / 1ps
`default_nettype none
package cap_pkg;

  localparam int ID_W      = 5;
  localparam int SIZE_IN_W = 16;
  localparam int ALIGN_W   = 5;
  localparam int MASK_W    = 32;
  localparam int ADDR_W    = 22;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

endpackage
`default_nettype wire

// ----- hw/rtl/cap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cap_mod.sv -----
// Bit-serial remainder unit: dividend modulo a small divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cap_mod #(
  parameter int CW = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [CW-1:0]               dividend,
  input  wire logic [cap_pkg::ALIGN_W-1:0] divisor,
  output logic                             done,
  output logic      [cap_pkg::ALIGN_W-1:0] rem
);
  import cap_pkg::*;

  localparam int CNT_W = $clog2(CW + 1);

  logic [CW-1:0]      shreg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [ALIGN_W:0]   trial;
  logic               fits;

  // shift next dividend bit into the partial remainder, subtract if it fits
  assign trial = {rem, shreg[CW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(CW);
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        shreg <= shreg << 1;
        rem   <= fits ? ALIGN_W'(trial - {1'b0, divisor}) : ALIGN_W'(trial);
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/conflict_aware_offset_placer.sv -----
// Conflict-aware offset placer: greedy first-fit placement over a table in RAM.
// Operation: each pass aligns the candidate (serial remainder, CW = 24 by
//   default) and then scans the table; at most placed_count+1 passes, then a
//   commit state.
// Throughput: one transaction at a time; in_ready is low from accept until commit.
// Reset (rst, synchronous): clears entry count, max end and handshake state;
//   the table RAM is not cleared, only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
module conflict_aware_offset_placer #(
  parameter int MAX_ALLOCS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          start_new_set,
  input  wire logic [cap_pkg::ID_W-1:0]      alloc_id,
  input  wire logic [cap_pkg::SIZE_IN_W-1:0] byte_size,
  input  wire logic [cap_pkg::ALIGN_W-1:0]   align_bytes,
  input  wire logic [cap_pkg::MASK_W-1:0]    conflict_mask,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [cap_pkg::ADDR_W-1:0]    start_address,
  output logic      [cap_pkg::ADDR_W-1:0]    total_used,
  output logic                               table_full
);
  import cap_pkg::*;

  // effective size width: only the low SIZE_BITS of byte_size count
  localparam int SW     = (SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;
  // candidate width: aligned start plus size never overflows this
  localparam int CW     = ((SW > ADDR_W) ? SW : ADDR_W) + 2;
  localparam int CNT_W  = $clog2(MAX_ALLOCS + 1);
  localparam int IDX_W  = $clog2(MAX_ALLOCS);
  localparam int PASS_W = $clog2(MAX_ALLOCS + 2);
  localparam int ENT_W  = ID_W + ADDR_W + SW;
  localparam int OE_W   = ADDR_W + 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MOD_GO  = 6'b000010,
    S_MOD_WT  = 6'b000100,
    S_END     = 6'b001000,
    S_SCAN    = 6'b010000,
    S_DECIDE  = 6'b100000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   max_end;

  // latched transaction
  logic [ID_W-1:0]     req_id;
  logic [SW-1:0]       req_size;
  logic [ALIGN_W-1:0]  req_align;
  logic [MASK_W-1:0]   req_mask;

  // search state
  logic [CW-1:0]       cand;
  logic [CW-1:0]       cand_end;
  logic [PASS_W-1:0]   pass_cnt;
  logic [CNT_W-1:0]    ridx;
  logic                rd_pend;
  logic                hit;
  logic [OE_W-1:0]     hit_end;
  logic                fail;

  // remainder unit
  logic                mod_start;
  logic                mod_done;
  logic [ALIGN_W-1:0]  mod_rem;

  // table RAM
  logic                ram_we;
  logic                ram_re;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;

  // scanned entry
  logic [ID_W-1:0]     o_id;
  logic [ADDR_W-1:0]   o_start;
  logic [SW-1:0]       o_size;
  logic [OE_W-1:0]     o_end;
  logic                o_conf;
  logic                o_meet;

  logic                slot_free;
  logic [CW-1:0]       new_end;

  assign in_ready  = (state == S_IDLE);
  assign mod_start = (state == S_MOD_GO);
  assign slot_free = !out_valid || out_ready;

  assign ram_re    = (state == S_SCAN) && (ridx < count);
  assign ram_we    = (state == S_DECIDE) && slot_free && !fail;
  assign ram_wdata = {req_id, cand[ADDR_W-1:0], req_size};

  assign o_id    = ram_rdata[ENT_W-1 -: ID_W];
  assign o_start = ram_rdata[SW+ADDR_W-1 -: ADDR_W];
  assign o_size  = ram_rdata[SW-1:0];
  assign o_end   = {1'b0, o_start} + OE_W'(o_size);
  // an entry with the same id always conflicts
  assign o_conf  = (o_id == req_id) || req_mask[o_id];
  // half-open overlap: [cand, cand_end) against [o_start, o_end)
  assign o_meet  = (cand < CW'(o_end)) && (CW'(o_start) < cand_end);

  assign new_end = cand_end;

  cap_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cand),
    .divisor  (req_align),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  cap_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ALLOCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      max_end   <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      // commit state reloads the output register itself
      if (out_valid && out_ready && (state != S_DECIDE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_id    <= alloc_id;
            req_size  <= byte_size[SW-1:0];
            // zero alignment behaves as byte alignment
            req_align <= (align_bytes == '0) ? ALIGN_W'(1) : align_bytes;
            req_mask  <= conflict_mask;
            cand      <= '0;
            pass_cnt  <= '0;
            if (start_new_set) begin
              count   <= '0;
              max_end <= '0;
              fail    <= 1'b0;
              state   <= S_MOD_GO;
            end else if (count == CNT_W'(MAX_ALLOCS)) begin
              // table full: refuse without searching
              fail    <= 1'b1;
              state   <= S_DECIDE;
            end else begin
              fail    <= 1'b0;
              state   <= S_MOD_GO;
            end
          end
        end

        S_MOD_GO: begin
          state <= S_MOD_WT;
        end

        S_MOD_WT: begin
          if (mod_done) begin
            // round candidate up to the alignment
            if (mod_rem != '0) begin
              cand <= cand + CW'(req_align - mod_rem);
            end
            state <= S_END;
          end
        end

        S_END: begin
          cand_end <= cand + CW'(req_size);
          ridx     <= '0;
          rd_pend  <= 1'b0;
          hit      <= 1'b0;
          hit_end  <= '0;
          state    <= S_SCAN;
        end

        S_SCAN: begin
          // read of entry ridx overlaps the check of the previous entry
          rd_pend <= ram_re;
          if (ram_re) begin
            ridx <= ridx + 1'b1;
          end
          if (rd_pend && o_conf && o_meet) begin
            hit <= 1'b1;
            if (o_end > hit_end) begin
              hit_end <= o_end;
            end
          end
          if (!ram_re && !rd_pend) begin
            if (!hit) begin
              // free spot; refuse if it runs past the address space
              fail  <= cand_end > CW'(ADDR_MAX);
              state <= S_DECIDE;
            end else if (pass_cnt == PASS_W'(MAX_ALLOCS + 1)) begin
              fail  <= 1'b1;
              state <= S_DECIDE;
            end else begin
              cand     <= CW'(hit_end);
              pass_cnt <= pass_cnt + 1'b1;
              state    <= S_MOD_GO;
            end
          end
        end

        S_DECIDE: begin
          // commit only once the output register is free
          if (slot_free) begin
            out_valid <= 1'b1;
            if (fail) begin
              start_address <= '0;
              total_used    <= max_end;
              table_full    <= 1'b1;
            end else begin
              count         <= count + 1'b1;
              start_address <= cand[ADDR_W-1:0];
              table_full    <= 1'b0;
              if (new_end > CW'(max_end)) begin
                max_end    <= new_end[ADDR_W-1:0];
                total_used <= new_end[ADDR_W-1:0];
              end else begin
                total_used <= max_end;
              end
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/conflict_aware_offset_placer_tb.sv -----
// Self-checking testbench for the conflict-aware offset placer.
`timescale 1ns / 1ps
module conflict_aware_offset_placer_tb;
  import cap_pkg::*;

  localparam int MAX_ALLOCS = 32;
  localparam int RANDOM_ITEMS = 540;
  localparam int IDLE_PCT = 27;
  localparam int HOLD_AT = 100;          // accepted count that triggers the long sink hold
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_LO = 250;          // no idling on either side in [CALM_LO, CALM_HI)
  localparam int CALM_HI = 330;
  localparam int DRAIN_CYCLES = 2500;    // idle time after the last result before finishing
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic                 new_set;
    logic [ID_W-1:0]      id;
    logic [SIZE_IN_W-1:0] size;
    logic [ALIGN_W-1:0]   align;
    logic [MASK_W-1:0]    mask;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] used;
    logic              full;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_new_set = 1'b0;
  logic [ID_W-1:0] alloc_id = '0;
  logic [SIZE_IN_W-1:0] byte_size = '0;
  logic [ALIGN_W-1:0] align_bytes = '0;
  logic [MASK_W-1:0] conflict_mask = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] start_address;
  logic [ADDR_W-1:0] total_used;
  logic table_full;

  conflict_aware_offset_placer #(
    .MAX_ALLOCS(MAX_ALLOCS),
    .SIZE_BITS (16)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_new_set(start_new_set),
    .alloc_id     (alloc_id),
    .byte_size    (byte_size),
    .align_bytes  (align_bytes),
    .conflict_mask(conflict_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_address(start_address),
    .total_used   (total_used),
    .table_full   (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Placement predictor: its own copy of the placed table
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]      tbl_id    [MAX_ALLOCS];
  logic [ADDR_W-1:0]    tbl_start [MAX_ALLOCS];
  logic [SIZE_IN_W-1:0] tbl_size  [MAX_ALLOCS];
  int unsigned          tbl_count = 0;
  logic [ADDR_W-1:0]    tbl_max_end = '0;

  function automatic placement_t place_request(request_t r);
    longint unsigned cand, cand_end, hit_end, ob, oe, al;
    bit hit, conf, done, ok;
    placement_t res;
    if (r.new_set) begin
      tbl_count = 0;
      tbl_max_end = '0;
    end
    al = (r.align == 0) ? 1 : r.align;
    cand = 0;
    cand_end = 0;
    ok = 1'b0;
    done = 1'b0;
    if (tbl_count < MAX_ALLOCS) begin
      // each pass: align, then jump past the furthest overlapping conflict
      for (int pass = 0; pass < MAX_ALLOCS + 2 && !done; pass++) begin
        if (cand % al != 0) cand += al - cand % al;
        cand_end = cand + r.size;
        hit = 1'b0;
        hit_end = 0;
        for (int i = 0; i < tbl_count; i++) begin
          // own id always conflicts, whatever the mask says
          conf = (tbl_id[i] == r.id) || r.mask[tbl_id[i]];
          ob = tbl_start[i];
          oe = ob + tbl_size[i];
          if (conf && cand < oe && ob < cand_end) begin
            hit = 1'b1;
            if (oe > hit_end) hit_end = oe;
          end
        end
        if (!hit) begin
          ok = (cand_end <= ADDR_MAX);
          done = 1'b1;
        end else begin
          cand = hit_end;
        end
      end
    end
    if (ok) begin
      tbl_id[tbl_count] = r.id;
      tbl_start[tbl_count] = cand[ADDR_W-1:0];
      tbl_size[tbl_count] = r.size;
      tbl_count++;
      if (cand_end > tbl_max_end) tbl_max_end = cand_end[ADDR_W-1:0];
      res.addr = cand[ADDR_W-1:0];
      res.full = 1'b0;
    end else begin
      // full table or exhausted address space: nothing placed
      res.addr = '0;
      res.full = 1'b1;
    end
    res.used = tbl_max_end;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue, driver, sink
  // ---------------------------------------------------------------------------
  request_t   req_q[$];
  placement_t expected_q[$];
  int         accepted_cnt = 0;
  int         errors = 0;
  logic       in_taken = 1'b0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  longint     cycle_cnt = 0;
  logic       calm;

  assign calm = (accepted_cnt >= CALM_LO) && (accepted_cnt < CALM_HI);

  task automatic add_request(input logic ns, input logic [ID_W-1:0] id,
                             input logic [SIZE_IN_W-1:0] size,
                             input logic [ALIGN_W-1:0] align,
                             input logic [MASK_W-1:0] mask);
    request_t r;
    r.new_set = ns;
    r.id = id;
    r.size = size;
    r.align = align;
    r.mask = mask;
    req_q.insert(req_q.size(), r);
  endtask

  // Driver: payload changes at the falling edge only when no transaction is pending.
  always @(negedge clk) begin
    request_t nxt;
    if (!rst && (!in_valid || in_taken)) begin
      if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = req_q.pop_front();
        start_new_set <= nxt.new_set;
        alloc_id <= nxt.id;
        byte_size <= nxt.size;
        align_bytes <= nxt.align;
        conflict_mask <= nxt.mask;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink: random stalls plus one long hold-off so the block backs up its input.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: predict on input transactions, check on output transactions.
  always @(posedge clk) begin
    request_t   cur;
    placement_t exp_res;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        cur.new_set = start_new_set;
        cur.id = alloc_id;
        cur.size = byte_size;
        cur.align = align_bytes;
        cur.mask = conflict_mask;
        exp_res = place_request(cur);
        expected_q.insert(expected_q.size(), exp_res);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result addr %0d used %0d full %0b",
                   $time, start_address, total_used, table_full);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (start_address !== exp_res.addr) begin
            $display("%0t: start_address expected %0d actual %0d",
                     $time, exp_res.addr, start_address);
            errors++;
          end
          if (total_used !== exp_res.used) begin
            $display("%0t: total_used expected %0d actual %0d",
                     $time, exp_res.used, total_used);
            errors++;
          end
          if (table_full !== exp_res.full) begin
            $display("%0t: table_full expected %0b actual %0b",
                     $time, exp_res.full, table_full);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build and run control
  // ---------------------------------------------------------------------------
  initial begin
    int ids[MAX_ALLOCS];
    int set_len, j, tmp, made;
    logic [SIZE_IN_W-1:0] sz;
    logic [MASK_W-1:0] msk;
    logic [ID_W-1:0] rid;

    // directed: extremes, odd alignments, own-id conflict, zero size, mid-set restart
    add_request(1'b1, 5'd0, 16'hFFFF, 5'd1, 32'h0);
    add_request(1'b0, 5'd1, 16'd16, 5'd16, 32'h1);
    add_request(1'b0, 5'd2, 16'd0, 5'd0, 32'hFFFF_FFFF);
    add_request(1'b0, 5'd1, 16'd8, 5'd3, 32'h0);
    add_request(1'b0, 5'd31, 16'd1, 5'd31, 32'h8000_0000);
    add_request(1'b0, 5'd3, 16'd100, 5'd5, 32'h7FFF_FFFF);
    add_request(1'b0, 5'd4, 16'd0, 5'd16, 32'h0000_0002);
    add_request(1'b0, 5'd5, 16'hFFFF, 5'd31, 32'hFFFF_FFFF);
    add_request(1'b0, 5'd6, 16'd0, 5'd7, 32'h0000_0020);
    add_request(1'b0, 5'd7, 16'h8000, 5'd0, 32'hAAAA_AAAA);
    add_request(1'b1, 5'd10, 16'h5555, 5'd2, 32'h5555_5555);
    add_request(1'b0, 5'd10, 16'hAAAA, 5'd17, 32'h0);
    add_request(1'b0, 5'd11, 16'd1, 5'd16, 32'hFFFF_FFFF);

    // random sets: mostly unique ids per set, some long enough to fill the table
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if (made == 0 || $urandom_range(3) == 0) set_len = $urandom_range(33, 40);
      else set_len = $urandom_range(1, 24);
      for (int k = 0; k < MAX_ALLOCS; k++) ids[k] = k;
      for (int k = MAX_ALLOCS - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = ids[k];
        ids[k] = ids[j];
        ids[j] = tmp;
      end
      for (int k = 0; k < set_len && made < RANDOM_ITEMS; k++) begin
        if (k >= MAX_ALLOCS || $urandom_range(9) == 0) rid = ID_W'($urandom_range(31));
        else rid = ID_W'(ids[k]);
        case ($urandom_range(7))
          0:       sz = '0;
          1:       sz = '1;
          2, 3:    sz = SIZE_IN_W'($urandom);
          default: sz = SIZE_IN_W'($urandom_range(1, 256));
        endcase
        case ($urandom_range(5))
          0:       msk = '0;
          1:       msk = '1;
          default: msk = $urandom;
        endcase
        // occasional restart in the middle of a set as noise
        add_request((k == 0) || ($urandom_range(49) == 0), rid, sz,
                    ALIGN_W'($urandom_range(31)), msk);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
